@@ rtl/core/stpr_pkg.sv @@
// Package for the stereo two-pole resonator core.
// Frame types, coefficient reset values and register indexes; no dependencies.
`default_nettype none

package stpr_pkg;

  localparam int SampleW = 16;
  localparam int CoefW   = 24;
  localparam int CfgIdxW = 2;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic signed [CoefW-1:0]   coef_t;
  typedef logic [CfgIdxW-1:0]        cfg_idx_t;

  typedef struct packed {
    sample_t left_in;
    sample_t right_in;
  } in_frame_t;

  typedef struct packed {
    sample_t left_out;
    sample_t right_out;
  } out_frame_t;

  localparam cfg_idx_t REG_INPUT_GAIN      = 2'd0;
  localparam cfg_idx_t REG_FIRST_FEEDBACK  = 2'd1;
  localparam cfg_idx_t REG_SECOND_FEEDBACK = 2'd2;

  localparam coef_t INPUT_GAIN_RESET      = 24'sd29407;
  localparam coef_t FIRST_FEEDBACK_RESET  = 24'sd2002497;
  localparam coef_t SECOND_FEEDBACK_RESET = -24'sd1038116;

  localparam int SampleMax = 32767;
  localparam int SampleMin = -32768;

endpackage

`default_nettype wire

@@ rtl/core/stereo_two_pole_resonator_core.sv @@
// A result is registered at the edge that takes the input transfer.
// Throughput: one stereo frame per cycle while out_ready does not stall the output; the
// combinational multiply, add and saturate loop through the output history sets that figure.
// The output register frees in_ready whenever the result is taken or none is held.
// Reset (synchronous, rst high): history cleared to zero, coefficients to defaults,
// no result held.
`default_nettype none

module stereo_two_pole_resonator_core
  import stpr_pkg::*;
#(
  parameter int COEF_FRAC_BITS = 20
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire in_frame_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output out_frame_t      out_data,
  input  wire logic       cfg_wr_en,
  input  wire cfg_idx_t   cfg_index,
  input  wire coef_t      cfg_data
);

  localparam int ProdW = SampleW + CoefW;
  localparam int TermW = ProdW - COEF_FRAC_BITS;
  localparam int SumW  = (TermW + 2 > SampleW + 1) ? TermW + 2 : SampleW + 1;

  localparam logic signed [SumW-1:0] SatMax = SumW'(SampleMax);
  localparam logic signed [SumW-1:0] SatMin = SumW'(SampleMin);

  coef_t   input_gain_coef;
  coef_t   first_feedback_coef;
  coef_t   second_feedback_coef;
  sample_t left_prev_one;
  sample_t left_prev_two;
  sample_t right_prev_one;
  sample_t right_prev_two;

  sample_t left_next;
  sample_t right_next;
  logic    accept;

  function automatic logic signed [SumW-1:0] scaled_term(input sample_t s, input coef_t c);
    logic signed [ProdW-1:0] p;
    logic [TermW-1:0]        q;
    logic                    round_up;
    p        = s * c;
    q        = p[ProdW-1:COEF_FRAC_BITS];
    round_up = p[ProdW-1] & (|p[COEF_FRAC_BITS-1:0]);
    q        = q + {{(TermW-1){1'b0}}, round_up};
    return {{(SumW-TermW){q[TermW-1]}}, q};
  endfunction

  function automatic sample_t resonate(input sample_t x, input sample_t y1, input sample_t y2,
                                       input coef_t g, input coef_t a1, input coef_t a2);
    logic signed [SumW-1:0] sum;
    sum = scaled_term(x, g) + scaled_term(y1, a1) + scaled_term(y2, a2);
    if (sum > SatMax) begin
      return sample_t'(SampleMax);
    end else if (sum < SatMin) begin
      return sample_t'(SampleMin);
    end
    return sum[SampleW-1:0];
  endfunction

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    left_next  = resonate(in_data.left_in, left_prev_one, left_prev_two,
                          input_gain_coef, first_feedback_coef, second_feedback_coef);
    right_next = resonate(in_data.right_in, right_prev_one, right_prev_two,
                          input_gain_coef, first_feedback_coef, second_feedback_coef);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      input_gain_coef      <= INPUT_GAIN_RESET;
      first_feedback_coef  <= FIRST_FEEDBACK_RESET;
      second_feedback_coef <= SECOND_FEEDBACK_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_INPUT_GAIN:      input_gain_coef      <= cfg_data;
        REG_FIRST_FEEDBACK:  first_feedback_coef  <= cfg_data;
        REG_SECOND_FEEDBACK: second_feedback_coef <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_prev_one  <= '0;
      left_prev_two  <= '0;
      right_prev_one <= '0;
      right_prev_two <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        left_prev_one  <= left_next;
        left_prev_two  <= left_prev_one;
        right_prev_one <= right_next;
        right_prev_two <= right_prev_one;
        out_valid      <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data.left_out  <= left_next;
      out_data.right_out <= right_next;
    end
  end

`ifndef SYNTHESIS
  a_history_matches_output: assert property (@(posedge clk) disable iff (rst)
    accept |=> (left_prev_one == out_data.left_out) && (right_prev_one == out_data.right_out))
    else $error("history does not match delivered frame");

  a_history_shifts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (left_prev_two == $past(left_prev_one)) &&
               (right_prev_two == $past(right_prev_one)))
    else $error("history did not shift on transfer");

  a_history_holds: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(left_prev_one) && $stable(right_prev_one))
    else $error("history changed without a transfer");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");
`endif

endmodule

`default_nettype wire
